### rtl/tst_pkg.sv
// Shared constants, command and status codes, and date/time check functions.
package tst_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int OWN_W = 16;
	localparam int KEY_W = 32;
	localparam int ENT_W = OWN_W + KEY_W;
	localparam int CNT_W = 5;

	localparam logic [2:0] CMD_INSERT    = 3'd0;
	localparam logic [2:0] CMD_COUNT_ALL = 3'd1;
	localparam logic [2:0] CMD_COUNT_DAY = 3'd2;
	localparam logic [2:0] CMD_READ_MIN  = 3'd3;
	localparam logic [2:0] CMD_DEL_MIN   = 3'd4;
	localparam logic [2:0] CMD_DEL_OWNER = 3'd5;
	localparam logic [2:0] CMD_CLEAR     = 3'd6;

	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_FULL     = 3'd1;
	localparam logic [2:0] STAT_BAD_DATE = 3'd2;
	localparam logic [2:0] STAT_BAD_TIME = 3'd3;
	localparam logic [2:0] STAT_EMPTY    = 3'd4;

	// Reciprocal of 25 in 16 fractional bits; exact floor for 12-bit years.
	localparam logic [23:0] RECIP_25 = 24'd2622;

	function automatic logic [4:0] month_days(input logic [3:0] m);
		logic [4:0] len;
		case (m) inside
			4'd2: len = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// q25 is floor(y / 25), worked out beforehand and held in a register
	function automatic logic date_ok(input logic [4:0] d, input logic [3:0] m,
		input logic [11:0] y, input logic [7:0] q25);
		logic [11:0] r25;
		logic leap;
		logic [5:0] lim;
		r25 = y - (12'(q25) * 12'd25);
		leap = (y[1:0] == 2'd0) && ((r25 != 12'd0) || (y[3:0] == 4'd0));
		lim = {1'b0, month_days(m)} + {5'd0, (m == 4'd2) && leap};
		return (y != 12'd0) && (d != 5'd0) && (m != 4'd0) && (m <= 4'd12)
			&& ({1'b0, d} <= lim);
	endfunction

	function automatic logic time_ok(input logic [4:0] h, input logic [5:0] mi);
		return (h >= 5'd1) && (h <= 5'd23) && (mi <= 6'd60);
	endfunction

endpackage

### rtl/tst_ram.sv
// Generic simple dual-port RAM with registered read.
module tst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/timestamped_slot_table_unit.sv
// Slot table: each request scans every slot once through the entry RAM.
// From request accept the unit runs the scan, drain and finish states, then loads the result register.
// A new request is taken only in idle, once the last one has left finish; the RAM scan reads one slot per cycle.
// A result waiting in the output register does not block the next request until its end.
// Reset: asynchronous, active low; empties the table (valid bits cleared), RAM not touched.
module timestamped_slot_table_unit
	import tst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [2:0]  cmd,
	input  logic [15:0] owner,
	input  logic [4:0]  day,
	input  logic [3:0]  month,
	input  logic [11:0] year,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [2:0]  status,
	output logic [4:0]  count,
	output logic [15:0] found_owner,
	output logic [4:0]  found_day,
	output logic [3:0]  found_month,
	output logic [11:0] found_year,
	output logic [4:0]  found_hour,
	output logic [5:0]  found_minute
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]       state_q;
	logic [SLOTS-1:0] used_q;
	logic [IDX_W-1:0] rd_q;
	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;

	logic [2:0]  cmd_q;
	logic [15:0] owner_q;
	logic [4:0]  day_q;
	logic [3:0]  month_q;
	logic [11:0] year_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [7:0]  q25_q;

	logic [CNT_W-1:0] cnt_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             best_found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [KEY_W-1:0] best_key_q;
	logic [OWN_W-1:0] best_owner_q;

	logic             res_valid_q;
	logic [2:0]       status_q;
	logic [4:0]       count_q;
	logic [15:0]      found_owner_q;
	logic [KEY_W-1:0] found_key_q;

	logic             accept;
	logic             fin_go;
	logic [ENT_W-1:0] rd_data;
	logic [KEY_W-1:0] s1_key;
	logic [OWN_W-1:0] s1_owner;
	logic             s1_used;
	logic             s1_date_hit;
	logic             s1_better;
	logic [23:0]      yprod;
	logic             d_ok;
	logic             t_ok;
	logic             ins_ok;
	logic [KEY_W-1:0] new_key;

	logic [2:0]       status_n;
	logic [4:0]       count_n;
	logic [15:0]      owner_n;
	logic [KEY_W-1:0] key_n;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign fin_go    = (state_q == ST_FIN) && (!res_valid_q || res_ready);

	assign s1_key      = rd_data[KEY_W-1:0];
	assign s1_owner    = rd_data[ENT_W-1:KEY_W];
	assign s1_used     = used_q[idx_s1];
	assign s1_date_hit = (s1_key[31:11] == {year_q, month_q, day_q});
	assign s1_better   = !best_found_q || (s1_key < best_key_q);

	assign yprod   = 24'(year_q) * RECIP_25;
	assign d_ok    = date_ok(day_q, month_q, year_q, q25_q);
	assign t_ok    = time_ok(hour_q, minute_q);
	assign ins_ok  = free_found_q && d_ok && t_ok;
	assign new_key = {year_q, month_q, day_q, hour_q, minute_q};

	tst_ram #(
		.WIDTH(ENT_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (fin_go && (cmd_q == CMD_INSERT) && ins_ok),
		.waddr(free_idx_q),
		.wdata({owner_q, new_key}),
		.re   (state_q == ST_SCAN),
		.raddr(rd_q),
		.rdata(rd_data)
	);

	// result of the finished scan
	always_comb begin
		status_n = STAT_OK;
		count_n  = '0;
		owner_n  = '0;
		key_n    = '0;
		case (cmd_q)
			CMD_INSERT: begin
				if (!free_found_q) begin
					status_n = STAT_FULL;
				end else if (!d_ok) begin
					status_n = STAT_BAD_DATE;
				end else if (!t_ok) begin
					status_n = STAT_BAD_TIME;
				end
			end
			CMD_COUNT_ALL: begin
				count_n = cnt_q;
			end
			CMD_COUNT_DAY: begin
				if (!d_ok) begin
					status_n = STAT_BAD_DATE;
				end else begin
					count_n = cnt_q;
				end
			end
			CMD_READ_MIN: begin
				if (!best_found_q) begin
					status_n = STAT_EMPTY;
				end else begin
					owner_n = best_owner_q;
					key_n   = best_key_q;
				end
			end
			CMD_DEL_MIN: begin
				if (!best_found_q) begin
					status_n = STAT_EMPTY;
				end
			end
			default: begin
				status_n = STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			used_q       <= '0;
			rd_q         <= '0;
			v_s1         <= 1'b0;
			idx_s1       <= '0;
			cnt_q        <= '0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			v_s1   <= (state_q == ST_SCAN);
			idx_s1 <= rd_q;

			// one slot per cycle from the RAM read stage
			if (v_s1 && s1_used) begin
				if (((cmd_q == CMD_COUNT_ALL) || s1_date_hit) && (cnt_q != '1)) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (s1_better) begin
					best_found_q <= 1'b1;
				end
				if ((cmd_q == CMD_DEL_OWNER) && (s1_owner == owner_q)) begin
					used_q[idx_s1] <= 1'b0;
				end
			end
			if (v_s1 && !s1_used && !free_found_q) begin
				free_found_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q      <= ST_SCAN;
						rd_q         <= '0;
						cnt_q        <= '0;
						free_found_q <= 1'b0;
						best_found_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					rd_q <= rd_q + 1'b1;
					if (rd_q == IDX_W'(SLOTS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						case (cmd_q)
							CMD_INSERT: begin
								if (ins_ok) begin
									used_q[free_idx_q] <= 1'b1;
								end
							end
							CMD_DEL_MIN: begin
								if (best_found_q) begin
									used_q[best_idx_q] <= 1'b0;
								end
							end
							CMD_CLEAR: begin
								used_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			owner_q  <= owner;
			day_q    <= day;
			month_q  <= month;
			year_q   <= year;
			hour_q   <= hour;
			minute_q <= minute;
		end
		q25_q <= yprod[23:16];
		if (v_s1 && !s1_used && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
		if (v_s1 && s1_used && s1_better) begin
			best_idx_q   <= idx_s1;
			best_key_q   <= s1_key;
			best_owner_q <= s1_owner;
		end
		if (fin_go) begin
			status_q      <= status_n;
			count_q       <= count_n;
			found_owner_q <= owner_n;
			found_key_q   <= key_n;
		end
	end

	assign res_valid    = res_valid_q;
	assign status       = status_q;
	assign count        = count_q;
	assign found_owner  = found_owner_q;
	assign found_year   = found_key_q[31:20];
	assign found_month  = found_key_q[19:16];
	assign found_day    = found_key_q[15:11];
	assign found_hour   = found_key_q[10:6];
	assign found_minute = found_key_q[5:0];

endmodule

### rtl/tst_checker.sv
// Port-level checker for the slot table, bound to the top level.
module tst_checker
	import tst_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  status,
	input logic [4:0]  count,
	input logic [15:0] found_owner
);

	logic [1:0] pend_q;

	// requests taken whose result has not yet been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_valid && req_ready) - 2'(res_valid && res_ready);
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status) && $stable(count))
		else $error("result changed while stalled");

	a_res_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q != 2'd0)
		else $error("result without a request");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> (pend_q == 2'd0) || res_valid)
		else $error("new request taken while one is still in work");

	a_err_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status != STAT_OK) |-> (count == 5'd0) && (found_owner == 16'd0))
		else $error("error result carries data");

endmodule

bind timestamped_slot_table_unit tst_checker u_tst_checker (.*);

### bench/tb_timestamped_slot_table_unit.sv
// Self-checking testbench for the timestamped slot table: directed table, then random requests.
`timescale 1ns / 1ps

module tb_timestamped_slot_table_unit
	import tst_pkg::*;
;

	localparam logic [2:0] CMD_UNUSED = 3'd7;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] owner;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
		logic [4:0]  hour;
		logic [5:0]  minute;
	} slot_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  count;
		logic [15:0] owner;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
		logic [4:0]  hour;
		logic [5:0]  minute;
	} slot_res_t;

	typedef struct {
		slot_req_t q;
		bit        typed;
		slot_res_t r;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic [2:0]  cmd = '0;
	logic [15:0] owner = '0;
	logic [4:0]  day = '0;
	logic [3:0]  month = '0;
	logic [11:0] year = '0;
	logic [4:0]  hour = '0;
	logic [5:0]  minute = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [2:0]  status;
	logic [4:0]  count;
	logic [15:0] found_owner;
	logic [4:0]  found_day;
	logic [3:0]  found_month;
	logic [11:0] found_year;
	logic [4:0]  found_hour;
	logic [5:0]  found_minute;

	// predictor's own copy of the table
	logic        held [SLOTS];
	logic [15:0] held_owner [SLOTS];
	logic [31:0] held_stamp [SLOTS];

	slot_res_t answers_due [$];
	dir_row_t  dir_rows [$];
	int        errors = 0;
	int        send_pct = 0;
	int        recv_pct = 0;

	int         mix_th [3][7] = '{'{60, 68, 78, 86, 91, 95, 96},
		'{20, 28, 38, 53, 83, 95, 96}, '{40, 48, 60, 72, 84, 93, 95}};
	logic [2:0] cmd_of [7] = '{CMD_INSERT, CMD_COUNT_ALL, CMD_COUNT_DAY, CMD_READ_MIN,
		CMD_DEL_MIN, CMD_DEL_OWNER, CMD_CLEAR};
	int          yr_set [9] = '{1, 4, 100, 400, 1900, 2000, 2024, 2100, 4095};
	logic [15:0] owner_pool [4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h00A5};
	int          idle_send [4] = '{0, 62, 0, 24};
	int          idle_recv [4] = '{0, 0, 62, 24};

	timestamped_slot_table_unit dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready),
		.cmd(cmd), .owner(owner), .day(day), .month(month), .year(year),
		.hour(hour), .minute(minute),
		.res_valid(res_valid), .res_ready(res_ready),
		.status(status), .count(count), .found_owner(found_owner),
		.found_day(found_day), .found_month(found_month), .found_year(found_year),
		.found_hour(found_hour), .found_minute(found_minute)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int days_in_month(input int m, input int y);
		if (m == 2)
			return ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	function automatic bit calendar_ok(input int d, input int m, input int y);
		return y >= 1 && m >= 1 && m <= 12 && d >= 1 && d <= days_in_month(m, y);
	endfunction

	function automatic slot_res_t status_only(input logic [2:0] st);
		slot_res_t r;
		r = '0;
		r.status = st;
		return r;
	endfunction

	// Applies one request to the predicted table and returns the answer it should give.
	function automatic slot_res_t predict_slots(input slot_req_t q);
		slot_res_t r;
		logic [31:0] stamp;
		int i, free_i, best, n;
		r = '0;
		free_i = -1;
		best = -1;
		n = 0;
		stamp = {q.year, q.month, q.day, q.hour, q.minute};
		for (i = 0; i < SLOTS; i++) begin
			if (!held[i] && free_i < 0)
				free_i = i;
			if (held[i]) begin
				n++;
				if (best < 0 || held_stamp[i] < held_stamp[best])
					best = i;
			end
		end
		case (q.cmd)
			CMD_INSERT: begin
				if (free_i < 0)
					r.status = STAT_FULL;
				else if (!calendar_ok(q.day, q.month, q.year))
					r.status = STAT_BAD_DATE;
				else if (q.hour < 1 || q.hour > 23 || q.minute > 60)
					r.status = STAT_BAD_TIME;
				else begin
					held[free_i] = 1'b1;
					held_owner[free_i] = q.owner;
					held_stamp[free_i] = stamp;
				end
			end
			CMD_COUNT_ALL: r.count = 5'((n > 31) ? 31 : n);
			CMD_COUNT_DAY: begin
				if (!calendar_ok(q.day, q.month, q.year))
					r.status = STAT_BAD_DATE;
				else begin
					n = 0;
					for (i = 0; i < SLOTS; i++)
						if (held[i] && held_stamp[i][31:11] == stamp[31:11])
							n++;
					r.count = 5'((n > 31) ? 31 : n);
				end
			end
			CMD_READ_MIN: begin
				if (best < 0)
					r.status = STAT_EMPTY;
				else begin
					r.owner  = held_owner[best];
					r.year   = held_stamp[best][31:20];
					r.month  = held_stamp[best][19:16];
					r.day    = held_stamp[best][15:11];
					r.hour   = held_stamp[best][10:6];
					r.minute = held_stamp[best][5:0];
				end
			end
			CMD_DEL_MIN: begin
				if (best < 0)
					r.status = STAT_EMPTY;
				else
					held[best] = 1'b0;
			end
			CMD_DEL_OWNER: begin
				for (i = 0; i < SLOTS; i++)
					if (held[i] && held_owner[i] == q.owner)
						held[i] = 1'b0;
			end
			CMD_CLEAR: begin
				for (i = 0; i < SLOTS; i++)
					held[i] = 1'b0;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic add_row(input slot_req_t q, input bit typed, input slot_res_t r);
		dir_row_t row;
		row.q = q;
		row.typed = typed;
		row.r = r;
		dir_rows = {dir_rows, row};
	endtask

	// Leaves valid high on return so a back-to-back request needs no second assignment.
	task automatic send_request(input slot_req_t q, input bit typed, input slot_res_t given);
		slot_res_t model;
		while ($urandom_range(99) < send_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		cmd    <= q.cmd;
		owner  <= q.owner;
		day    <= q.day;
		month  <= q.month;
		year   <= q.year;
		hour   <= q.hour;
		minute <= q.minute;
		do @(posedge clk); while (!req_ready);
		model = predict_slots(q);
		answers_due = {answers_due, (typed ? given : model)};
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk)
		res_ready <= ($urandom_range(99) >= recv_pct);

	always @(posedge clk) begin : result_check
		slot_res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (answers_due.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				want = answers_due.pop_front();
				check_field("status", want.status, status);
				check_field("count", want.count, count);
				check_field("found_owner", want.owner, found_owner);
				check_field("found_day", want.day, found_day);
				check_field("found_month", want.month, found_month);
				check_field("found_year", want.year, found_year);
				check_field("found_hour", want.hour, found_hour);
				check_field("found_minute", want.minute, found_minute);
			end
		end
	end

	initial begin
		#1000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		slot_req_t q, src;
		slot_req_t recent [$];
		int blk, j, k, pick, profile, yr, mo;

		for (k = 0; k < SLOTS; k++)
			held[k] = 1'b0;
		profile = 0;

		add_row('{CMD_READ_MIN, 16'd0, 5'd0, 4'd0, 12'd0, 5'd0, 6'd0}, 1,
			status_only(STAT_EMPTY));
		add_row('{CMD_DEL_MIN, 16'd0, 5'd0, 4'd0, 12'd0, 5'd0, 6'd0}, 1,
			status_only(STAT_EMPTY));
		add_row('{CMD_COUNT_ALL, 16'd0, 5'd0, 4'd0, 12'd0, 5'd0, 6'd0}, 1,
			status_only(STAT_OK));
		// date failures: year zero, month out of range, day zero, no leap day in 1900
		add_row('{CMD_INSERT, 16'd1, 5'd1, 4'd1, 12'd0, 5'd1, 6'd0}, 1,
			status_only(STAT_BAD_DATE));
		add_row('{CMD_INSERT, 16'd1, 5'd1, 4'd13, 12'd2024, 5'd12, 6'd30}, 1,
			status_only(STAT_BAD_DATE));
		add_row('{CMD_INSERT, 16'd1, 5'd1, 4'd0, 12'd2024, 5'd12, 6'd30}, 1,
			status_only(STAT_BAD_DATE));
		add_row('{CMD_INSERT, 16'd1, 5'd0, 4'd1, 12'd2024, 5'd12, 6'd30}, 1,
			status_only(STAT_BAD_DATE));
		add_row('{CMD_INSERT, 16'd1, 5'd29, 4'd2, 12'd1900, 5'd10, 6'd0}, 1,
			status_only(STAT_BAD_DATE));
		// 2000 is a leap year, so only the hour is wrong
		add_row('{CMD_INSERT, 16'd1, 5'd29, 4'd2, 12'd2000, 5'd0, 6'd0}, 1,
			status_only(STAT_BAD_TIME));
		add_row('{CMD_INSERT, 16'd1, 5'd15, 4'd6, 12'd2024, 5'd24, 6'd0}, 1,
			status_only(STAT_BAD_TIME));
		add_row('{CMD_INSERT, 16'd1, 5'd15, 4'd6, 12'd2024, 5'd12, 6'd61}, 1,
			status_only(STAT_BAD_TIME));
		add_row('{CMD_INSERT, 16'hFFFF, 5'd29, 4'd2, 12'd2024, 5'd23, 6'd60}, 1,
			status_only(STAT_OK));
		add_row('{CMD_INSERT, 16'h0000, 5'd31, 4'd12, 12'd4095, 5'd1, 6'd0}, 1,
			status_only(STAT_OK));
		add_row('{CMD_INSERT, 16'd7, 5'd1, 4'd1, 12'd1, 5'd1, 6'd0}, 1,
			status_only(STAT_OK));
		add_row('{CMD_READ_MIN, 16'd0, 5'd0, 4'd0, 12'd0, 5'd0, 6'd0}, 1,
			'{STAT_OK, 5'd0, 16'd7, 5'd1, 4'd1, 12'd1, 5'd1, 6'd0});
		add_row('{CMD_COUNT_DAY, 16'd0, 5'd29, 4'd2, 12'd2024, 5'd0, 6'd0}, 1,
			'{STAT_OK, 5'd1, 16'd0, 5'd0, 4'd0, 12'd0, 5'd0, 6'd0});
		add_row('{CMD_COUNT_DAY, 16'd0, 5'd31, 4'd4, 12'd2024, 5'd0, 6'd0}, 1,
			status_only(STAT_BAD_DATE));
		add_row('{CMD_DEL_OWNER, 16'hFFFF, 5'd0, 4'd0, 12'd0, 5'd0, 6'd0}, 1,
			status_only(STAT_OK));
		add_row('{CMD_COUNT_ALL, 16'd0, 5'd0, 4'd0, 12'd0, 5'd0, 6'd0}, 1,
			'{STAT_OK, 5'd2, 16'd0, 5'd0, 4'd0, 12'd0, 5'd0, 6'd0});
		add_row('{CMD_DEL_OWNER, 16'h1234, 5'd0, 4'd0, 12'd0, 5'd0, 6'd0}, 0, '0);
		add_row('{CMD_DEL_MIN, 16'd0, 5'd0, 4'd0, 12'd0, 5'd0, 6'd0}, 0, '0);
		add_row('{CMD_READ_MIN, 16'd0, 5'd0, 4'd0, 12'd0, 5'd0, 6'd0}, 1,
			'{STAT_OK, 5'd0, 16'd0, 5'd31, 4'd12, 12'd4095, 5'd1, 6'd0});
		add_row('{CMD_UNUSED, 16'hFFFF, 5'd31, 4'd15, 12'd4095, 5'd31, 6'd63}, 1,
			status_only(STAT_OK));
		add_row('{CMD_CLEAR, 16'd0, 5'd0, 4'd0, 12'd0, 5'd0, 6'd0}, 0, '0);
		add_row('{CMD_COUNT_ALL, 16'd0, 5'd0, 4'd0, 12'd0, 5'd0, 6'd0}, 1,
			status_only(STAT_OK));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i].q, dir_rows[i].typed, dir_rows[i].r);

		for (blk = 0; blk < 10; blk++) begin
			send_pct = idle_send[blk % 4];
			recv_pct = idle_recv[blk % 4];
			for (j = 0; j < 150; j++) begin
				// fill-heavy, drain-heavy or mixed runs of thirty requests
				if (j % 30 == 0)
					profile = $urandom_range(2);
				pick = $urandom_range(99);
				k = 0;
				while (k < 7 && pick >= mix_th[profile][k])
					k++;
				q.cmd    = 3'($urandom);
				q.owner  = 16'($urandom);
				q.day    = 5'($urandom);
				q.month  = 4'($urandom);
				q.year   = 12'($urandom);
				q.hour   = 5'($urandom);
				q.minute = 6'($urandom);
				if (k < 7) begin
					q.cmd = cmd_of[k];
					if ($urandom_range(99) < 70)
						q.owner = owner_pool[$urandom_range(3)];
					if ((q.cmd == CMD_INSERT || q.cmd == CMD_COUNT_DAY)
						&& $urandom_range(99) < 85) begin
						// reuse a recent stamp for ties and date matches
						if (recent.size() != 0 && $urandom_range(99)
							< ((q.cmd == CMD_INSERT) ? 35 : 60)) begin
							src = recent[$urandom_range(recent.size() - 1)];
							q.day    = src.day;
							q.month  = src.month;
							q.year   = src.year;
							q.hour   = src.hour;
							q.minute = src.minute;
						end else begin
							yr = ($urandom_range(99) < 40) ? yr_set[$urandom_range(8)]
								: $urandom_range(4095, 1);
							mo = $urandom_range(12, 1);
							q.year   = 12'(yr);
							q.month  = 4'(mo);
							q.day    = 5'($urandom_range(days_in_month(mo, yr), 1));
							q.hour   = 5'($urandom_range(23, 1));
							q.minute = 6'($urandom_range(60));
						end
						if (q.cmd == CMD_INSERT) begin
							if ($urandom_range(99) < 10) begin
								q.hour   = 5'($urandom);
								q.minute = 6'($urandom);
							end else begin
								recent = {recent, q};
								if (recent.size() > 8)
									void'(recent.pop_front());
							end
						end
					end
				end
				send_request(q, 0, '0);
			end
		end
		req_valid <= 1'b0;

		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (2 * (SLOTS + 3)) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
